// ===== rtl/mtg_pkg.sv =====
// Shared types and constants for the multi-tap gesture detector.
package mtg_pkg;

   // Touch event kinds.
   localparam logic [1:0] ACT_BEGAN  = 2'd0;
   localparam logic [1:0] ACT_MOVED  = 2'd1;
   localparam logic [1:0] ACT_ENDED  = 2'd2;
   localparam logic [1:0] ACT_CANCEL = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REQUIRED_TAPS      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TAP_TIMEOUT_MS     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOUCH_TIMEOUT_MS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TAP_DISTANCE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_TOUCH_DISTANCE = 3'd4;

   localparam int unsigned CSR_DATA_WIDTH = 16;

   // Register values after reset.
   localparam logic [3:0]  RST_REQUIRED_TAPS      = 4'd1;
   localparam logic [15:0] RST_TAP_TIMEOUT_MS     = 16'd750;
   localparam logic [15:0] RST_TOUCH_TIMEOUT_MS   = 16'd250;
   localparam logic [7:0]  RST_MAX_TAP_DISTANCE   = 8'd20;
   localparam logic [7:0]  RST_MAX_TOUCH_DISTANCE = 8'd10;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  touch_count;
      logic [31:0] time_ms;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
   } mtg_req_type;

   typedef struct packed {
      logic        tap_detected;
      logic [11:0] tap_x;
      logic [11:0] tap_y;
   } mtg_rsp_type;

   typedef struct packed {
      logic [3:0]  required_taps;
      logic [15:0] tap_timeout_ms;
      logic [15:0] touch_timeout_ms;
      logic [7:0]  max_tap_distance;
      logic [7:0]  max_touch_distance;
   } mtg_cfg_type;

   typedef struct packed {
      logic        start_valid;
      logic [3:0]  tap_counter;
      logic [31:0] start_time;
      logic [11:0] start_x;
      logic [11:0] start_y;
   } mtg_state_type;

endpackage

// ===== rtl/mtg_step.sv =====
// Combinational step of the tap recognizer: next sequence state and result for one event.
module mtg_step (
   input  mtg_pkg::mtg_cfg_type   cfg,
   input  mtg_pkg::mtg_state_type state,
   input  mtg_pkg::mtg_req_type   req,
   output mtg_pkg::mtg_state_type state_next,
   output mtg_pkg::mtg_rsp_type   rsp
);

   logic        is_ended;
   logic [15:0] time_limit;
   logic [7:0]  radius;
   logic [31:0] dt;
   logic        time_ok;
   logic [11:0] dx;
   logic [11:0] dy;
   logic [23:0] dx_sq;
   logic [23:0] dy_sq;
   logic [24:0] dist_sq;
   logic [15:0] radius_sq;
   logic        dist_ok;
   logic [3:0]  count_inc;

   // Began events are checked against the tap limits, ended events against the touch limits,
   // so one timer compare and one distance unit serve both.
   assign is_ended   = (req.action == mtg_pkg::ACT_ENDED);
   assign time_limit = is_ended ? cfg.touch_timeout_ms : cfg.tap_timeout_ms;
   assign radius     = is_ended ? cfg.max_touch_distance : cfg.max_tap_distance;

   // A negative wrapped time difference counts as within the limit.
   assign dt      = req.time_ms - state.start_time;
   assign time_ok = dt[31] || (dt < {16'd0, time_limit});

   assign dx = (req.pos_x >= state.start_x) ? (req.pos_x - state.start_x)
                                            : (state.start_x - req.pos_x);
   assign dy = (req.pos_y >= state.start_y) ? (req.pos_y - state.start_y)
                                            : (state.start_y - req.pos_y);
   assign dx_sq     = {12'd0, dx} * {12'd0, dx};
   assign dy_sq     = {12'd0, dy} * {12'd0, dy};
   assign dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign radius_sq = {8'd0, radius} * {8'd0, radius};
   assign dist_ok   = dist_sq < {9'd0, radius_sq};

   assign count_inc = state.tap_counter + 4'd1;

   always_comb begin
      state_next = state;
      rsp        = '0;
      if ((req.touch_count > 4'd1) || (req.action == mtg_pkg::ACT_CANCEL)) begin
         state_next = '0;
      end else begin
         unique case (req.action) inside
            mtg_pkg::ACT_BEGAN: begin
               if ((state.tap_counter != 4'd0) && !(time_ok && dist_ok)) begin
                  state_next.tap_counter = 4'd0;
               end
               state_next.start_valid = 1'b1;
               state_next.start_time  = req.time_ms;
               state_next.start_x     = req.pos_x;
               state_next.start_y     = req.pos_y;
            end
            mtg_pkg::ACT_ENDED: begin
               if (state.start_valid && time_ok && dist_ok) begin
                  if (count_inc == cfg.required_taps) begin
                     state_next       = '0;
                     rsp.tap_detected = 1'b1;
                     rsp.tap_x        = req.pos_x;
                     rsp.tap_y        = req.pos_y;
                  end else begin
                     state_next.tap_counter = count_inc;
                     state_next.start_time  = req.time_ms;
                     state_next.start_x     = req.pos_x;
                     state_next.start_y     = req.pos_y;
                  end
               end
            end
            mtg_pkg::ACT_MOVED, mtg_pkg::ACT_CANCEL: begin
               state_next = state;
            end
            default: begin
               state_next = state;
            end
         endcase
      end
   end

endmodule

// ===== rtl/multi_tap_gesture_detector_unit.sv =====
// Top level of the multi-tap gesture detector: handshakes, registers and configuration.
//
//   channel   direction   ports                                   one transaction
//   req       in          req_valid, req_ready, req_payload       one touch event
//   rsp       out         rsp_valid, rsp_ready, rsp_payload       one result per event
//   csr       in          csr_write_en, csr_index, csr_wdata      one register write
//
// Every event gives exactly one result: the event sits in the input register while the
// recognizer step works on it, and the outcome lands in the result register when the
// event moves on.
// A new event is taken in every cycle while results keep draining.
// The recognizer state is read and written in the same stage, so consecutive events see
// each other's updates with no forwarding.
// Reset is synchronous and active high; it empties both registers, loads the register
// defaults and clears the tap sequence. There is no clearing pass.
// When the result register is full and not taken, the event in the input register waits
// and req_ready drops in the same cycle.
module multi_tap_gesture_detector_unit (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mtg_pkg::mtg_req_type                   req_payload,

   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mtg_pkg::mtg_rsp_type                   rsp_payload,

   input  logic                                   csr_write_en,
   input  logic [mtg_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mtg_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // Input register holding the event under work.
   logic                  s1_valid_ff;
   mtg_pkg::mtg_req_type  s1_req_ff;

   // Result register.
   logic                  rsp_valid_ff;
   mtg_pkg::mtg_rsp_type  rsp_ff;
   mtg_pkg::mtg_rsp_type  rsp_in;

   // Tap sequence state and configuration registers.
   mtg_pkg::mtg_state_type state_ff;
   mtg_pkg::mtg_state_type state_in;
   mtg_pkg::mtg_cfg_type   cfg_ff;
   mtg_pkg::mtg_cfg_type   cfg_in;

   logic advance;

   // The event in the input register moves on whenever the result register is free
   // or is being emptied in this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   mtg_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .req        (s1_req_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // Register writes take the low bits of the write data; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mtg_pkg::CSR_REQUIRED_TAPS:      cfg_in.required_taps      = csr_wdata[3:0];
            mtg_pkg::CSR_TAP_TIMEOUT_MS:     cfg_in.tap_timeout_ms     = csr_wdata[15:0];
            mtg_pkg::CSR_TOUCH_TIMEOUT_MS:   cfg_in.touch_timeout_ms   = csr_wdata[15:0];
            mtg_pkg::CSR_MAX_TAP_DISTANCE:   cfg_in.max_tap_distance   = csr_wdata[7:0];
            mtg_pkg::CSR_MAX_TOUCH_DISTANCE: cfg_in.max_touch_distance = csr_wdata[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         state_ff                    <= '0;
         cfg_ff.required_taps        <= mtg_pkg::RST_REQUIRED_TAPS;
         cfg_ff.tap_timeout_ms       <= mtg_pkg::RST_TAP_TIMEOUT_MS;
         cfg_ff.touch_timeout_ms     <= mtg_pkg::RST_TOUCH_TIMEOUT_MS;
         cfg_ff.max_tap_distance     <= mtg_pkg::RST_MAX_TAP_DISTANCE;
         cfg_ff.max_touch_distance   <= mtg_pkg::RST_MAX_TOUCH_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/mtg_checker.sv =====
// Port-level assertions for the multi-tap gesture detector and their bind.
module mtg_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mtg_pkg::mtg_rsp_type rsp_payload
);

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A result without a detected tap carries a zero position.
   a_zero_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.tap_detected) |->
         (rsp_payload.tap_x == 12'd0) && (rsp_payload.tap_y == 12'd0))
      else $error("position set on a result without a tap");

   // The input side only stalls when a finished result is waiting to be taken.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the result side was free");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind multi_tap_gesture_detector_unit mtg_checker u_mtg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the multi-tap gesture detector unit.
module testbench;

   // One entry of the stimulus queue: either a touch event or a register write.
   typedef struct packed {
      logic                                is_write;
      logic [mtg_pkg::CSR_INDEX_WIDTH-1:0] index;
      logic [mtg_pkg::CSR_DATA_WIDTH-1:0]  data;
      mtg_pkg::mtg_req_type                ev;
   } pending_op_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   mtg_pkg::mtg_req_type                req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   mtg_pkg::mtg_rsp_type                rsp_payload;
   logic                                csr_write_en = 1'b0;
   logic [mtg_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [mtg_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   pending_op_type       pending_ops[$];
   mtg_pkg::mtg_rsp_type expected_results[$];

   // Mirror of the recognizer: the register values and the tap sequence state.
   mtg_pkg::mtg_cfg_type    settings;
   mtg_pkg::mtg_state_type  track = '0;
   // Register values the stimulus generator is currently shaping events for.
   mtg_pkg::mtg_cfg_type    plan;

   int unsigned events_sent = 0;
   int unsigned results_seen = 0;
   int unsigned gestures_seen = 0;
   int unsigned writes_sent = 0;
   int unsigned settings_loaded = 0;
   int unsigned error_count = 0;

   // A window in the middle of the run where neither side idles at random.
   logic quiet;
   assign quiet = (events_sent >= 700) && (events_sent < 1000);

   multi_tap_gesture_detector_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Elapsed time since the stored event, read as a signed 32-bit difference, so a
   // timestamp that lies before the stored one always counts as within the limit.
   function automatic logic within_time(logic [31:0] stamp, logic [15:0] limit);
      logic [31:0] elapsed;
      elapsed = stamp - track.start_time;
      return $signed(elapsed) < $signed({16'd0, limit});
   endfunction

   // Squared distance to the stored point against the squared radius; a zero radius
   // can never pass.
   function automatic logic within_radius(logic [11:0] x, logic [11:0] y,
                                          logic [7:0] radius);
      logic [31:0] dx, dy, r;
      dx = {20'd0, x} - {20'd0, track.start_x};
      if (x < track.start_x) dx = {20'd0, track.start_x} - {20'd0, x};
      dy = {20'd0, y} - {20'd0, track.start_y};
      if (y < track.start_y) dy = {20'd0, track.start_y} - {20'd0, y};
      r = {24'd0, radius};
      return dx * dx + dy * dy < r * r;
   endfunction

   // Advances the mirrored tap sequence by one touch event and returns the result
   // the block must give for it.
   function automatic mtg_pkg::mtg_rsp_type gesture_step(mtg_pkg::mtg_req_type ev);
      mtg_pkg::mtg_rsp_type res;
      res = '0;
      if (ev.touch_count > 4'd1 || ev.action == mtg_pkg::ACT_CANCEL) begin
         // A second finger or a cancel abandons whatever was in progress.
         track = '0;
      end else if (ev.action == mtg_pkg::ACT_BEGAN) begin
         if (track.tap_counter != 4'd0 &&
             (!within_time(ev.time_ms, settings.tap_timeout_ms) ||
              !within_radius(ev.pos_x, ev.pos_y, settings.max_tap_distance))) begin
            track.tap_counter = 4'd0;
         end
         track.start_valid = 1'b1;
         track.start_time  = ev.time_ms;
         track.start_x     = ev.pos_x;
         track.start_y     = ev.pos_y;
      end else if (ev.action == mtg_pkg::ACT_ENDED && track.start_valid) begin
         if (within_time(ev.time_ms, settings.touch_timeout_ms) &&
             within_radius(ev.pos_x, ev.pos_y, settings.max_touch_distance)) begin
            // The counter wraps at 16, which is how a required count of zero completes.
            track.tap_counter = track.tap_counter + 4'd1;
            track.start_time  = ev.time_ms;
            track.start_x     = ev.pos_x;
            track.start_y     = ev.pos_y;
            if (track.tap_counter == settings.required_taps) begin
               track = '0;
               res.tap_detected = 1'b1;
               res.tap_x        = ev.pos_x;
               res.tap_y        = ev.pos_y;
            end
         end
      end
      return res;
   endfunction

   task automatic queue_event(logic [1:0] action, logic [3:0] fingers, logic [31:0] stamp,
                              logic [11:0] x, logic [11:0] y);
      pending_op_type op;
      op = '0;
      op.ev.action      = action;
      op.ev.touch_count = fingers;
      op.ev.time_ms     = stamp;
      op.ev.pos_x       = x;
      op.ev.pos_y       = y;
      pending_ops.push_back(op);
   endtask

   // Queues writes of all five registers; the driver holds them back until the block
   // has drained.
   task automatic queue_settings(logic [3:0] taps, logic [15:0] tap_ms, logic [15:0] touch_ms,
                                 logic [7:0] tap_dist, logic [7:0] touch_dist);
      pending_op_type op;
      op = '0;
      op.is_write = 1'b1;
      op.index = mtg_pkg::CSR_REQUIRED_TAPS;
      op.data  = {12'd0, taps};
      pending_ops.push_back(op);
      op.index = mtg_pkg::CSR_TAP_TIMEOUT_MS;
      op.data  = tap_ms;
      pending_ops.push_back(op);
      op.index = mtg_pkg::CSR_TOUCH_TIMEOUT_MS;
      op.data  = touch_ms;
      pending_ops.push_back(op);
      op.index = mtg_pkg::CSR_MAX_TAP_DISTANCE;
      op.data  = {8'd0, tap_dist};
      pending_ops.push_back(op);
      op.index = mtg_pkg::CSR_MAX_TOUCH_DISTANCE;
      op.data  = {8'd0, touch_dist};
      pending_ops.push_back(op);
      plan.required_taps      = taps;
      plan.tap_timeout_ms     = tap_ms;
      plan.touch_timeout_ms   = touch_ms;
      plan.max_tap_distance   = tap_dist;
      plan.max_touch_distance = touch_dist;
      settings_loaded++;
   endtask

   // A time gap aimed at a limit: mostly inside it, often right on either side of the
   // boundary, sometimes well past it, and now and then stepping backwards.
   function automatic logic [31:0] time_step(logic [15:0] limit);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return (limit == 16'd0) ? 32'd0 : $urandom_range(0, limit - 16'd1);
      else if (pick < 78) return (limit == 16'd0) ? 32'd0 : {16'd0, limit - 16'd1};
      else if (pick < 86) return {16'd0, limit};
      else if (pick < 95) return {16'd0, limit} + $urandom_range(1, 500);
      else return 32'd0 - $urandom_range(1, 100);
   endfunction

   // A point near base, usually well inside the radius, sometimes a little outside.
   function automatic logic [11:0] nudge(logic [11:0] base, logic [7:0] radius);
      int span, pos;
      span = ($urandom_range(99) < 85) ? (int'(radius) * 7) / 10 : int'(radius) + 3;
      pos = int'(base) - span + int'($urandom_range(0, 2 * span));
      if (pos < 0) pos = 0;
      if (pos > 4095) pos = 4095;
      return pos[11:0];
   endfunction

   // Mostly complete tap gestures with random timing and jitter around the current
   // limits, mixed with stray moves, cancels, extra fingers and fully random events.
   // Single-finger moves are ignored by the block and not counted toward the target.
   task automatic queue_random_phase(int unsigned target);
      int unsigned made, taps, k, n;
      logic [31:0] now;
      logic [11:0] px, py, bx, by;
      logic [3:0]  fingers;
      logic [1:0]  act;
      made = 0;
      now = $urandom;
      while (made < target) begin
         if ($urandom_range(99) < 15) begin
            for (n = $urandom_range(1, 3); n > 0; n--) begin
               act = 2'($urandom_range(3));
               fingers = 4'($urandom_range(15));
               if ($urandom_range(1) == 0) now = $urandom;
               else now = now + $urandom_range(0, 2000);
               queue_event(act, fingers, now, 12'($urandom_range(4095)),
                           12'($urandom_range(4095)));
               if (act != mtg_pkg::ACT_MOVED) made++;
            end
         end else begin
            taps = (plan.required_taps == 4'd0) ? 16 : 32'(plan.required_taps);
            if ($urandom_range(99) < 20) taps = $urandom_range(1, taps + 1);
            px = 12'($urandom_range(4095));
            py = 12'($urandom_range(4095));
            for (k = 0; k < taps; k++) begin
               if (k == 0) now = now + $urandom_range(0, 5000);
               else now = now + time_step(plan.tap_timeout_ms);
               bx = (k == 0) ? px : nudge(px, plan.max_tap_distance);
               by = (k == 0) ? py : nudge(py, plan.max_tap_distance);
               fingers = ($urandom_range(9) == 0) ? 4'd0 : 4'd1;
               queue_event(mtg_pkg::ACT_BEGAN, fingers, now, bx, by);
               made++;
               if ($urandom_range(99) < 25)
                  queue_event(mtg_pkg::ACT_MOVED, 4'd1, now + $urandom_range(0, 50),
                              nudge(bx, plan.max_touch_distance),
                              nudge(by, plan.max_touch_distance));
               if ($urandom_range(99) < 4) begin
                  if ($urandom_range(1) == 0)
                     queue_event(mtg_pkg::ACT_CANCEL, 4'd1, now, bx, by);
                  else
                     queue_event(mtg_pkg::ACT_MOVED, 4'($urandom_range(2, 15)), now, bx, by);
                  made++;
               end
               now = now + time_step(plan.touch_timeout_ms);
               px = nudge(bx, plan.max_touch_distance);
               py = nudge(by, plan.max_touch_distance);
               fingers = ($urandom_range(9) == 0) ? 4'd0 : 4'd1;
               queue_event(mtg_pkg::ACT_ENDED, fingers, now, px, py);
               made++;
            end
         end
      end
   endtask

   task automatic note_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   // Driver: presents queued events on the request channel and issues register writes
   // only once every expected result has come back. Each output is assigned once.
   always @(posedge clock) begin : driver
      pending_op_type                      head;
      logic                                fire;
      logic                                send_valid;
      mtg_pkg::mtg_req_type                send_payload;
      logic                                send_write;
      logic [mtg_pkg::CSR_INDEX_WIDTH-1:0] send_index;
      logic [mtg_pkg::CSR_DATA_WIDTH-1:0]  send_data;
      fire         = req_valid && req_ready;
      send_valid   = req_valid && !fire;
      send_payload = req_payload;
      send_write   = 1'b0;
      send_index   = csr_index;
      send_data    = csr_wdata;
      if (!reset) begin
         if (fire) begin
            expected_results.push_back(gesture_step(req_payload));
            events_sent++;
         end
         if (!send_valid && pending_ops.size() != 0) begin
            head = pending_ops[0];
            if (head.is_write) begin
               if (expected_results.size() == 0) begin
                  send_write = 1'b1;
                  send_index = head.index;
                  send_data  = head.data;
                  case (head.index)
                     mtg_pkg::CSR_REQUIRED_TAPS:
                        settings.required_taps = head.data[3:0];
                     mtg_pkg::CSR_TAP_TIMEOUT_MS:
                        settings.tap_timeout_ms = head.data;
                     mtg_pkg::CSR_TOUCH_TIMEOUT_MS:
                        settings.touch_timeout_ms = head.data;
                     mtg_pkg::CSR_MAX_TAP_DISTANCE:
                        settings.max_tap_distance = head.data[7:0];
                     mtg_pkg::CSR_MAX_TOUCH_DISTANCE:
                        settings.max_touch_distance = head.data[7:0];
                     default: ;
                  endcase
                  writes_sent++;
                  void'(pending_ops.pop_front());
               end
            end else if (quiet || $urandom_range(99) >= 22) begin
               send_valid   = 1'b1;
               send_payload = head.ev;
               void'(pending_ops.pop_front());
            end
         end
      end
      req_valid    <= send_valid;
      req_payload  <= send_payload;
      csr_write_en <= send_write;
      csr_index    <= send_index;
      csr_wdata    <= send_data;
   end

   // Monitor: takes results at random and checks each one against the oldest
   // expectation.
   always @(posedge clock) begin : monitor
      mtg_pkg::mtg_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            note_failure($sformatf("result with nothing expected: det=%0b x=%0d y=%0d",
                                   rsp_payload.tap_detected, rsp_payload.tap_x,
                                   rsp_payload.tap_y));
         end else begin
            want = expected_results.pop_front();
            if (want.tap_detected) gestures_seen++;
            if (rsp_payload.tap_detected !== want.tap_detected ||
                rsp_payload.tap_x !== want.tap_x || rsp_payload.tap_y !== want.tap_y) begin
               note_failure($sformatf(
                  "result %0d: expected det=%0b x=%0d y=%0d, got det=%0b x=%0d y=%0d",
                  results_seen, want.tap_detected, want.tap_x, want.tap_y,
                  rsp_payload.tap_detected, rsp_payload.tap_x, rsp_payload.tap_y));
            end
         end
      end
      rsp_ready <= quiet || ($urandom_range(99) >= 22);
   end

   initial begin : stimulus
      settings.required_taps      = mtg_pkg::RST_REQUIRED_TAPS;
      settings.tap_timeout_ms     = mtg_pkg::RST_TAP_TIMEOUT_MS;
      settings.touch_timeout_ms   = mtg_pkg::RST_TOUCH_TIMEOUT_MS;
      settings.max_tap_distance   = mtg_pkg::RST_MAX_TAP_DISTANCE;
      settings.max_touch_distance = mtg_pkg::RST_MAX_TOUCH_DISTANCE;
      plan = settings;

      // Directed events under the reset values: one tap makes a gesture.
      // A release with nothing stored, and a lone move, do nothing.
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd5, 12'd10, 12'd10);
      queue_event(mtg_pkg::ACT_MOVED, 4'd1, 32'd6, 12'd0, 12'd0);
      // A press at the origin and a release just inside both touch limits.
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd100, 12'd0, 12'd0);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd349, 12'd6, 12'd7);
      // At the far corner: a release exactly at the timeout, then one exactly on the
      // radius, both rejected; then a release with a zero finger count that passes.
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd1000, 12'd4095, 12'd4095);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd1250, 12'd4095, 12'd4095);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd1100, 12'd4089, 12'd4087);
      queue_event(mtg_pkg::ACT_ENDED, 4'd0, 32'd1100, 12'd4095, 12'd4095);
      // Timestamps that wrap past zero, and a release that lies before its press.
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'hFFFF_FFF0, 12'd2048, 12'd2048);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'h0000_0020, 12'd2048, 12'd2048);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'h8000_0000, 12'd1, 12'd2);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'h0000_0000, 12'd1, 12'd2);
      // A cancel, a move with many fingers and a two-finger press all drop the press.
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd500, 12'd3000, 12'd100);
      queue_event(mtg_pkg::ACT_CANCEL, 4'd1, 32'd505, 12'd3000, 12'd100);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd510, 12'd3000, 12'd100);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd600, 12'd2730, 12'd1365);
      queue_event(mtg_pkg::ACT_MOVED, 4'd15, 32'd601, 12'd2730, 12'd1365);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd602, 12'd2730, 12'd1365);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd2, 32'd700, 12'd1365, 12'd2730);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd701, 12'd1365, 12'd2730);

      // Double tap: the second press just inside the tap gap and radius completes,
      // while a second press exactly at the gap limit restarts the count.
      queue_settings(4'd2, 16'd750, 16'd250, 8'd20, 8'd10);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd10, 12'd500, 12'd500);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd20, 12'd500, 12'd500);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd769, 12'd519, 12'd500);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd770, 12'd519, 12'd500);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd1000, 12'd600, 12'd600);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd1001, 12'd600, 12'd600);
      queue_event(mtg_pkg::ACT_BEGAN, 4'd1, 32'd1751, 12'd600, 12'd600);
      queue_event(mtg_pkg::ACT_ENDED, 4'd1, 32'd1752, 12'd600, 12'd600);
      queue_random_phase(220);

      // Random phases across a spread of register settings, extremes included.
      queue_settings(4'd3, 16'd400, 16'd200, 8'd40, 8'd15);
      queue_random_phase(220);
      queue_settings(4'd15, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
      queue_random_phase(220);
      queue_settings(4'd1, 16'd0, 16'd0, 8'd0, 8'd0);
      queue_random_phase(100);
      queue_settings(4'd0, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
      queue_random_phase(220);
      queue_settings(mtg_pkg::RST_REQUIRED_TAPS, mtg_pkg::RST_TAP_TIMEOUT_MS,
                     mtg_pkg::RST_TOUCH_TIMEOUT_MS, mtg_pkg::RST_MAX_TAP_DISTANCE,
                     mtg_pkg::RST_MAX_TOUCH_DISTANCE);
      queue_random_phase(200);
      repeat (3) begin
         queue_settings(4'($urandom_range(1, 6)), 16'($urandom_range(50, 3000)),
                        16'($urandom_range(20, 1500)), 8'($urandom_range(1, 255)),
                        8'($urandom_range(1, 255)));
         queue_random_phase(240);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d touch events under %0d register settings (%0d register writes).",
               events_sent, settings_loaded, writes_sent);
      $display("Checked %0d results, %0d of them completed gestures; %0d mismatches.",
               results_seen, gestures_seen, error_count);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin : watchdog
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mtg_pkg.sv
rtl/mtg_step.sv
rtl/multi_tap_gesture_detector_unit.sv
rtl/mtg_checker.sv
test/testbench.sv
